### sv/lru_address_range_table_unit_assert.svh
// ---------------------------------------------------------------------------
// assertion macros for the lru address range table
// both macros sample on clk and are disabled while rst is high
// ---------------------------------------------------------------------------
`ifndef LRU_ADDRESS_RANGE_TABLE_UNIT_ASSERT_SVH
`define LRU_ADDRESS_RANGE_TABLE_UNIT_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define LRAT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lrat assertion failed");

// consequent holds in the cycle after the antecedent
`define LRAT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lrat assertion failed");

`endif

### sv/lrat_pkg.sv
// ---------------------------------------------------------------------------
// lrat_pkg
// shared constants, codes and controller/datapath structs
// ---------------------------------------------------------------------------
package lrat_pkg;

  localparam int LRAT_DEPTH     = 16;
  localparam int LRAT_ADDR_BITS = 32;
  localparam int OUT_W          = 32;
  localparam int MODE_W         = 3;
  localparam int STATUS_W       = 3;

  // request modes
  localparam logic [MODE_W-1:0] MODE_INSERT       = 3'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE       = 3'd1;
  localparam logic [MODE_W-1:0] MODE_LOOKUP       = 3'd2;
  localparam logic [MODE_W-1:0] MODE_LOOKUP_TOUCH = 3'd3;
  localparam logic [MODE_W-1:0] MODE_MODIFY       = 3'd4;
  localparam logic [MODE_W-1:0] MODE_MODIFY_TOUCH = 3'd5;
  localparam logic [MODE_W-1:0] MODE_EVICT        = 3'd6;
  localparam logic [MODE_W-1:0] MODE_CLEAR        = 3'd7;

  // response status
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OVERLAP   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

  // memory read address source
  localparam logic [1:0] RD_NONE   = 2'd0;
  localparam logic [1:0] RD_PTR    = 2'd1;
  localparam logic [1:0] RD_PTR_M1 = 2'd2;
  localparam logic [1:0] RD_LAST   = 2'd3;

  // walk pointer update
  localparam logic [2:0] PTR_HOLD     = 3'd0;
  localparam logic [2:0] PTR_ZERO     = 3'd1;
  localparam logic [2:0] PTR_INC      = 3'd2;
  localparam logic [2:0] PTR_DEC      = 3'd3;
  localparam logic [2:0] PTR_RIDX     = 3'd4;
  localparam logic [2:0] PTR_RIDX_INC = 3'd5;
  localparam logic [2:0] PTR_CNT      = 3'd6;

  // memory write source
  localparam logic [2:0] WR_NONE        = 3'd0;
  localparam logic [2:0] WR_UP          = 3'd1;
  localparam logic [2:0] WR_DOWN        = 3'd2;
  localparam logic [2:0] WR_RIDX_REPL   = 3'd3;
  localparam logic [2:0] WR_FRONT_NEW   = 3'd4;
  localparam logic [2:0] WR_FRONT_SAVED = 3'd5;
  localparam logic [2:0] WR_FRONT_REPL  = 3'd6;

  // entry count update
  localparam logic [1:0] CNT_HOLD = 2'd0;
  localparam logic [1:0] CNT_INC  = 2'd1;
  localparam logic [1:0] CNT_DEC  = 2'd2;
  localparam logic [1:0] CNT_CLR  = 2'd3;

  typedef struct packed {
    logic                in_ld;
    logic [1:0]          rd;
    logic [2:0]          ptr_op;
    logic [2:0]          wr;
    logic [1:0]          cnt_op;
    logic                hold_ld;
    logic                out_ld;
    logic [STATUS_W-1:0] out_status;
    logic                out_evict;
  } lrat_cmd_t;

  typedef struct packed {
    logic rd_valid;
    logic ovl;
    logic start_eq;
    logic end_eq;
    logic ptr_lt_cnt;
    logic ptr_zero;
    logic cnt_zero;
    logic cnt_full;
  } lrat_stat_t;

endpackage

### sv/lrat_req_if.sv
// ---------------------------------------------------------------------------
// lrat_req_if
// request channel: mode and address ranges with valid/ready
// ---------------------------------------------------------------------------
interface lrat_req_if import lrat_pkg::*; #(
  parameter int ADDR_BITS = LRAT_ADDR_BITS
) ();

  logic                 valid;
  logic                 ready;
  logic [MODE_W-1:0]    mode;
  logic [ADDR_BITS-1:0] range_start;
  logic [ADDR_BITS-1:0] range_end;
  logic [ADDR_BITS-1:0] replace_start;
  logic [ADDR_BITS-1:0] replace_end;

  modport source (
    output valid, mode, range_start, range_end, replace_start, replace_end,
    input  ready
  );

  modport sink (
    input  valid, mode, range_start, range_end, replace_start, replace_end,
    output ready
  );

endinterface

### sv/lrat_rsp_if.sv
// ---------------------------------------------------------------------------
// lrat_rsp_if
// response channel: status and evicted range with valid/ready
// ---------------------------------------------------------------------------
interface lrat_rsp_if import lrat_pkg::*; ();

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [OUT_W-1:0]    out_start;
  logic [OUT_W-1:0]    out_end;

  modport source (
    output valid, status, out_start, out_end,
    input  ready
  );

  modport sink (
    input  valid, status, out_start, out_end,
    output ready
  );

endinterface

### sv/lru_address_range_table_unit.sv
// ---------------------------------------------------------------------------
// lru_address_range_table_unit
// most-recently-used ordered table of address ranges
// ---------------------------------------------------------------------------
// req channel: one word per command (mode, range_start, range_end,
// replace_start, replace_end); accepted when valid and ready are high.
// rsp channel: one word per command (status, out_start, out_end).
// the table is a single-port-read, single-port-write memory of DEPTH
// entries; a command is carried out by walks over it, one entry a cycle.
// clear, and evict on an empty table, go straight to the result; evict
// reads the last entry; lookup and modify walk from the front until the
// entry is found; insert walks for an overlap, then shifts each entry back
// one place; remove closes the gap behind the entry; touch modes move it
// to the front, and modify touch writes the replacement there.
// ready is high only while no command is in progress; the next command is
// taken while the previous result still waits in the output register.
// a stalled receiver holds the result word; a finished command then waits
// for the output register to free up before returning to idle.
// reset empties the table at once (entry count to zero) and clears valid.
// ---------------------------------------------------------------------------
module lru_address_range_table_unit import lrat_pkg::*; #(
  parameter int DEPTH     = LRAT_DEPTH,
  parameter int ADDR_BITS = LRAT_ADDR_BITS
) (
  input logic        clk,
  input logic        rst,
  lrat_req_if.sink   req,
  lrat_rsp_if.source rsp
);

  lrat_cmd_t  cmd;
  lrat_stat_t stat;

  // sequencer
  lrat_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_mode  (req.mode),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // table storage and compares
  lrat_dp #(
    .DEPTH     (DEPTH),
    .ADDR_BITS (ADDR_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .range_start   (req.range_start),
    .range_end     (req.range_end),
    .replace_start (req.replace_start),
    .replace_end   (req.replace_end),
    .status        (rsp.status),
    .out_start     (rsp.out_start),
    .out_end       (rsp.out_end)
  );

endmodule

### sv/lrat_dp.sv
// ---------------------------------------------------------------------------
// lrat_dp
// range memory, walk pointer, entry count, compares and result register
// ---------------------------------------------------------------------------
module lrat_dp import lrat_pkg::*; #(
  parameter int DEPTH     = LRAT_DEPTH,
  parameter int ADDR_BITS = LRAT_ADDR_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  lrat_cmd_t            cmd,
  output lrat_stat_t           stat,
  input  logic [ADDR_BITS-1:0] range_start,
  input  logic [ADDR_BITS-1:0] range_end,
  input  logic [ADDR_BITS-1:0] replace_start,
  input  logic [ADDR_BITS-1:0] replace_end,
  output logic [STATUS_W-1:0]  status,
  output logic [OUT_W-1:0]     out_start,
  output logic [OUT_W-1:0]     out_end
);

  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int WORD_W = 2 * ADDR_BITS;

  logic [ADDR_BITS-1:0] key_start;
  logic [ADDR_BITS-1:0] key_end;
  logic [ADDR_BITS-1:0] repl_start;
  logic [ADDR_BITS-1:0] repl_end;

  logic [WORD_W-1:0]    mem [DEPTH];
  logic [WORD_W-1:0]    rd_word;
  logic [WORD_W-1:0]    hold_word;
  logic                 rd_valid;
  logic [IDX_W-1:0]     rd_idx;
  logic [CNT_W-1:0]     ptr;
  logic [CNT_W-1:0]     cnt;

  logic [ADDR_BITS-1:0] rd_start;
  logic [ADDR_BITS-1:0] rd_end;
  logic [ADDR_BITS-1:0] hold_start;
  logic [ADDR_BITS-1:0] hold_end;
  logic [CNT_W-1:0]     ptr_m1;
  logic [CNT_W-1:0]     cnt_m1;
  logic                 rd_en;
  logic [IDX_W-1:0]     ra;
  logic                 we;
  logic [IDX_W-1:0]     wa;
  logic [WORD_W-1:0]    wd;

  assign rd_start   = rd_word[WORD_W-1 -: ADDR_BITS];
  assign rd_end     = rd_word[ADDR_BITS-1:0];
  assign hold_start = hold_word[WORD_W-1 -: ADDR_BITS];
  assign hold_end   = hold_word[ADDR_BITS-1:0];
  assign ptr_m1     = ptr - CNT_W'(1);
  assign cnt_m1     = cnt - CNT_W'(1);

  // request word capture
  always_ff @(posedge clk) begin
    if (cmd.in_ld) begin
      key_start  <= range_start;
      key_end    <= range_end;
      repl_start <= replace_start;
      repl_end   <= replace_end;
    end
  end

  // read address select
  always_comb begin
    rd_en = 1'b1;
    ra    = ptr[IDX_W-1:0];
    case (cmd.rd)
      RD_PTR:    ra = ptr[IDX_W-1:0];
      RD_PTR_M1: ra = ptr_m1[IDX_W-1:0];
      RD_LAST:   ra = cnt_m1[IDX_W-1:0];
      default:   rd_en = 1'b0;
    endcase
  end

  // write address and data select
  always_comb begin
    we = 1'b0;
    wa = rd_idx;
    wd = rd_word;
    case (cmd.wr)
      WR_UP: begin
        we = rd_valid;
        wa = rd_idx + IDX_W'(1);
      end
      WR_DOWN: begin
        we = rd_valid;
        wa = rd_idx - IDX_W'(1);
      end
      WR_RIDX_REPL: begin
        we = 1'b1;
        wd = {repl_start, repl_end};
      end
      WR_FRONT_NEW: begin
        we = 1'b1;
        wa = '0;
        wd = {key_start, key_end};
      end
      WR_FRONT_SAVED: begin
        we = 1'b1;
        wa = '0;
        wd = hold_word;
      end
      WR_FRONT_REPL: begin
        we = 1'b1;
        wa = '0;
        wd = {repl_start, repl_end};
      end
      default: we = 1'b0;
    endcase
  end

  // range memory with registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_word <= mem[ra];
      rd_idx  <= ra;
    end
  end

  // read pending flag
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= rd_en;
    end
  end

  // walk pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else begin
      case (cmd.ptr_op)
        PTR_ZERO:     ptr <= '0;
        PTR_INC:      ptr <= ptr + CNT_W'(1);
        PTR_DEC:      ptr <= ptr_m1;
        PTR_RIDX:     ptr <= CNT_W'(rd_idx);
        PTR_RIDX_INC: ptr <= CNT_W'(rd_idx) + CNT_W'(1);
        PTR_CNT:      ptr <= cnt;
        default:      ptr <= ptr;
      endcase
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      case (cmd.cnt_op)
        CNT_INC: cnt <= cnt + CNT_W'(1);
        CNT_DEC: cnt <= cnt_m1;
        CNT_CLR: cnt <= '0;
        default: cnt <= cnt;
      endcase
    end
  end

  // saved entry for touch and evict
  always_ff @(posedge clk) begin
    if (cmd.hold_ld) begin
      hold_word <= rd_word;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      status    <= cmd.out_status;
      out_start <= cmd.out_evict ? OUT_W'(hold_start) : '0;
      out_end   <= cmd.out_evict ? OUT_W'(hold_end) : '0;
    end
  end

  // compares on the entry just read, the walk pointer and the entry count
  always_comb begin
    stat.rd_valid   = rd_valid;
    stat.ovl        = ((rd_start < key_start) && (rd_end >= key_start)) ||
                      ((rd_start <= key_end) && (rd_end > key_end));
    stat.start_eq   = (rd_start == key_start);
    stat.end_eq     = (rd_end == key_end);
    stat.ptr_lt_cnt = (ptr < cnt);
    stat.ptr_zero   = (ptr == '0);
    stat.cnt_zero   = (cnt == '0);
    stat.cnt_full   = (cnt >= CNT_W'(DEPTH));
  end

endmodule

### sv/lrat_ctrl.sv
// ---------------------------------------------------------------------------
// lrat_ctrl
// sequencer: search walk, shift walks, evict read and response handoff
// ---------------------------------------------------------------------------
module lrat_ctrl import lrat_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic [MODE_W-1:0] req_mode,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  input  lrat_stat_t        stat,
  output lrat_cmd_t         cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_SHUP = 3'd2;
  localparam logic [2:0] S_SHDN = 3'd3;
  localparam logic [2:0] S_EVRD = 3'd4;
  localparam logic [2:0] S_EVWT = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0]          state;
  logic [2:0]          state_next;
  logic [MODE_W-1:0]   mode;
  logic [MODE_W-1:0]   mode_next;
  logic [STATUS_W-1:0] code;
  logic [STATUS_W-1:0] code_next;
  logic                evict;
  logic                evict_next;
  logic                rsp_valid_next;
  logic                ovl_mode;
  logic                hit;

  assign req_ready = (state == S_IDLE);
  assign ovl_mode  = (mode == MODE_INSERT);
  assign hit       = stat.rd_valid && (ovl_mode ? stat.ovl : stat.start_eq);

  // next state and datapath commands
  always_comb begin
    state_next = state;
    mode_next  = mode;
    code_next  = code;
    evict_next = evict;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.in_ld  = 1'b1;
          mode_next  = req_mode;
          code_next  = ST_OK;
          evict_next = 1'b0;
          case (req_mode)
            MODE_CLEAR: begin
              cmd.cnt_op = CNT_CLR;
              state_next = S_FIN;
            end
            MODE_EVICT: begin
              if (stat.cnt_zero) begin
                code_next  = ST_EMPTY;
                state_next = S_FIN;
              end else begin
                state_next = S_EVRD;
              end
            end
            default: begin
              cmd.ptr_op = PTR_ZERO;
              state_next = S_SCAN;
            end
          endcase
        end
      end
      // front-to-back walk, one read issued per cycle
      S_SCAN: begin
        if (hit) begin
          if (ovl_mode) begin
            code_next  = ST_OVERLAP;
            state_next = S_FIN;
          end else if (!stat.end_eq) begin
            code_next  = ST_NOT_FOUND;
            state_next = S_FIN;
          end else begin
            cmd.hold_ld = 1'b1;
            case (mode)
              MODE_MODIFY: begin
                cmd.wr     = WR_RIDX_REPL;
                state_next = S_FIN;
              end
              MODE_REMOVE: begin
                cmd.ptr_op = PTR_RIDX_INC;
                state_next = S_SHDN;
              end
              MODE_LOOKUP_TOUCH, MODE_MODIFY_TOUCH: begin
                cmd.ptr_op = PTR_RIDX;
                state_next = S_SHUP;
              end
              default: state_next = S_FIN;
            endcase
          end
        end else if (!stat.rd_valid && !stat.ptr_lt_cnt) begin
          // walk ended with no hit
          if (!ovl_mode) begin
            code_next  = ST_NOT_FOUND;
            state_next = S_FIN;
          end else if (stat.cnt_full) begin
            code_next  = ST_FULL;
            state_next = S_FIN;
          end else begin
            cmd.ptr_op = PTR_CNT;
            state_next = S_SHUP;
          end
        end else if (stat.ptr_lt_cnt) begin
          cmd.rd     = RD_PTR;
          cmd.ptr_op = PTR_INC;
        end
      end
      // move entries one place back, then fill the front
      S_SHUP: begin
        cmd.wr = WR_UP;
        if (stat.ptr_zero && !stat.rd_valid) begin
          case (mode)
            MODE_INSERT: begin
              cmd.wr     = WR_FRONT_NEW;
              cmd.cnt_op = CNT_INC;
            end
            MODE_LOOKUP_TOUCH: cmd.wr = WR_FRONT_SAVED;
            default:           cmd.wr = WR_FRONT_REPL;
          endcase
          state_next = S_FIN;
        end else if (!stat.ptr_zero) begin
          cmd.rd     = RD_PTR_M1;
          cmd.ptr_op = PTR_DEC;
        end
      end
      // close the gap left by a removed entry
      S_SHDN: begin
        cmd.wr = WR_DOWN;
        if (!stat.ptr_lt_cnt && !stat.rd_valid) begin
          cmd.cnt_op = CNT_DEC;
          state_next = S_FIN;
        end else if (stat.ptr_lt_cnt) begin
          cmd.rd     = RD_PTR;
          cmd.ptr_op = PTR_INC;
        end
      end
      S_EVRD: begin
        cmd.rd     = RD_LAST;
        state_next = S_EVWT;
      end
      S_EVWT: begin
        cmd.hold_ld = 1'b1;
        cmd.cnt_op  = CNT_DEC;
        evict_next  = 1'b1;
        state_next  = S_FIN;
      end
      // hand the result word to the output register
      S_FIN: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.out_ld     = 1'b1;
          cmd.out_status = code;
          cmd.out_evict  = evict;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // output valid
  always_comb begin
    rsp_valid_next = rsp_valid;
    if (cmd.out_ld) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // per-request registers
  always_ff @(posedge clk) begin
    mode  <= mode_next;
    code  <= code_next;
    evict <= evict_next;
  end

endmodule

### sv/lrat_checker.sv
// ---------------------------------------------------------------------------
// lrat_checker
// port-level assertions for the lru address range table
// ---------------------------------------------------------------------------
`include "lru_address_range_table_unit_assert.svh"

module lrat_checker import lrat_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic [STATUS_W-1:0] status,
  input logic [OUT_W-1:0]    out_start,
  input logic [OUT_W-1:0]    out_end
);

  // a result word stays offered until taken
  `LRAT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

  // one command at a time: busy right after an accept
  `LRAT_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)

  // only defined status codes leave the block
  `LRAT_ASSERT_SAME(a_status_range, rsp_valid, status <= ST_EMPTY)

  // a command that does not end ok returns zeroed range data
  `LRAT_ASSERT_SAME(a_zero_data, rsp_valid && (status != ST_OK),
                    (out_start == '0) && (out_end == '0))

endmodule

bind lru_address_range_table_unit lrat_checker u_lrat_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .status    (rsp.status),
  .out_start (rsp.out_start),
  .out_end   (rsp.out_end)
);
